FILE: rtl/core/mbps_pkg.sv
`default_nettype none

package mbps_pkg;

  localparam int NUM_BALLS = 3;
  localparam int CRD_W     = 6;
  localparam int DIST2_W   = 14;
  localparam int ROOT_W    = 7;
  localparam int REM_W     = 10;
  localparam int TERM_W    = 8;
  localparam int NUM_W     = 16;
  localparam int THR_W     = 8;
  localparam int GAIN_W    = 8;
  localparam int IDX_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUMERATOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN      = 2'd2;

  localparam logic [NUM_W-1:0]  NUMERATOR_RST = 16'd640;
  localparam logic [THR_W-1:0]  THRESHOLD_RST = 8'd60;
  localparam logic [GAIN_W-1:0] GAIN_RST      = 8'd9;

  typedef logic [CRD_W-1:0]   crd_t;
  typedef logic [DIST2_W-1:0] dist2_t;
  typedef logic [TERM_W-1:0]  term_t;

  // digit-by-digit square root state
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sq_state_t;

  // restoring divider state, only the low quotient bits are kept
  typedef struct packed {
    logic [TERM_W-1:0] rem;
    logic [IDX_W-1:0]  quo;
  } dv_state_t;

  // one root bit: bring down two radicand bits, try (root << 2) | 1
  function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
    sq_state_t        r;
    logic [REM_W-1:0] acc;
    logic [REM_W-1:0] trial;
    acc   = {s.rem[REM_W-3:0], pair};
    trial = {1'b0, s.root, 2'b01};
    if (acc >= trial) begin
      r.rem  = acc - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.rem  = acc;
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // one quotient bit; remainder stays below the divisor
  function automatic dv_state_t div_step(dv_state_t s, logic nbit, term_t d);
    dv_state_t         r;
    logic [TERM_W:0]   acc;
    acc = {s.rem, nbit};
    if (acc >= {1'b0, d}) begin
      r.rem = TERM_W'(acc - {1'b0, d});
      r.quo = {s.quo[IDX_W-2:0], 1'b1};
    end else begin
      r.rem = acc[TERM_W-1:0];
      r.quo = {s.quo[IDX_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/metaball_pixel_shader_unit.sv
// Throughput: one word per cycle; eight register stages, the whole pipe stalls
// only while the output register holds a word that is not taken.
// Stages: distance, square root (two stages), sum and divide (four stages), gain.
// Reset: synchronous, active low; clears valid bits and loads register defaults.
// No clearing pass is needed; the block accepts input from the first cycle.
`default_nettype none

module metaball_pixel_shader_unit (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_pixel_x,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_pixel_y,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_a_x,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_a_y,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_b_x,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_b_y,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_c_x,
  input  wire  [mbps_pkg::CRD_W-1:0]            in_ball_c_y,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic [mbps_pkg::IDX_W-1:0]            out_palette_index,
  output logic                                  out_on_ball,
  input  wire                                   cfg_we,
  input  wire  [mbps_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [mbps_pkg::CFG_DAT_W-1:0]        cfg_wdata
);

  import mbps_pkg::*;

  // config
  logic [NUM_W-1:0]  numerator_r;
  logic [THR_W-1:0]  threshold_r;
  logic [GAIN_W-1:0] gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numerator_r <= NUMERATOR_RST;
      threshold_r <= THRESHOLD_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMERATOR: numerator_r <= cfg_wdata[NUM_W-1:0];
        CFG_THRESHOLD: threshold_r <= cfg_wdata[THR_W-1:0];
        CFG_GAIN:      gain_r      <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipe control
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  // stage 1: squared distances, on-ball flag
  crd_t   bx [NUM_BALLS];
  crd_t   by [NUM_BALLS];
  dist2_t d2_nxt [NUM_BALLS];
  dist2_t d2_s1_r [NUM_BALLS];
  logic   hit_nxt;
  logic   hit_s1_r, hit_s2_r, hit_s3_r, hit_s4_r, hit_s5_r, hit_s6_r, hit_s7_r;
  logic   hit_out_r;

  assign bx[0] = in_ball_a_x;
  assign by[0] = in_ball_a_y;
  assign bx[1] = in_ball_b_x;
  assign by[1] = in_ball_b_y;
  assign bx[2] = in_ball_c_x;
  assign by[2] = in_ball_c_y;

  always_comb begin
    crd_t dx;
    crd_t dy;
    hit_nxt = 1'b0;
    for (int i = 0; i < NUM_BALLS; i++) begin
      dx = (in_pixel_x > bx[i]) ? in_pixel_x - bx[i] : bx[i] - in_pixel_x;
      dy = (in_pixel_y > by[i]) ? in_pixel_y - by[i] : by[i] - in_pixel_y;
      d2_nxt[i] = DIST2_W'(dx * dx) + DIST2_W'(dy * dy);
      if (dx == '0 && dy == '0) hit_nxt = 1'b1;
    end
  end

  // stage 2: root bits 6..3
  sq_state_t  sq2_nxt [NUM_BALLS];
  sq_state_t  sq2_r   [NUM_BALLS];
  logic [5:0] lo2_r   [NUM_BALLS];

  always_comb begin
    sq_state_t st;
    for (int i = 0; i < NUM_BALLS; i++) begin
      st = '0;
      for (int k = ROOT_W - 1; k >= 3; k--) begin
        st = sqrt_step(st, d2_s1_r[i][2*k +: 2]);
      end
      sq2_nxt[i] = st;
    end
  end

  // stage 3: root bits 2..0, term = 2 * root
  term_t term_nxt [NUM_BALLS];
  term_t term_s3_r [NUM_BALLS];

  always_comb begin
    sq_state_t st;
    for (int i = 0; i < NUM_BALLS; i++) begin
      st = sq2_r[i];
      for (int k = 2; k >= 0; k--) begin
        st = sqrt_step(st, lo2_r[i][2*k +: 2]);
      end
      term_nxt[i] = {st.root, 1'b0};
    end
  end

  // stage 4: sum and quotient bits 15..12
  term_t            dvs_nxt;
  dv_state_t        dv4_nxt;
  term_t            dvs4_r, dvs5_r, dvs6_r;
  dv_state_t        dv4_r, dv5_r, dv6_r;
  logic [11:0]      num4_r;
  logic [7:0]       num5_r;
  logic [3:0]       num6_r;
  dv_state_t        dv5_nxt, dv6_nxt, dv7_nxt;
  logic [IDX_W-1:0] quo7_r;

  always_comb begin
    term_t     sum;
    dv_state_t st;
    sum     = term_s3_r[0] + term_s3_r[1] + term_s3_r[2];
    dvs_nxt = (sum == '0) ? term_t'(1) : sum;
    st      = '0;
    for (int k = 0; k < 4; k++) begin
      st = div_step(st, numerator_r[NUM_W-1-k], dvs_nxt);
    end
    dv4_nxt = st;
  end

  // stages 5..7: quotient bits 11..0
  always_comb begin
    dv_state_t st5;
    dv_state_t st6;
    dv_state_t st7;
    st5 = dv4_r;
    st6 = dv5_r;
    st7 = dv6_r;
    for (int k = 0; k < 4; k++) begin
      st5 = div_step(st5, num4_r[11-k], dvs4_r);
      st6 = div_step(st6, num5_r[7-k], dvs5_r);
      st7 = div_step(st7, num6_r[3-k], dvs6_r);
    end
    dv5_nxt = st5;
    dv6_nxt = st6;
    dv7_nxt = st7;
  end

  // output stage: threshold band and gain
  logic [IDX_W-1:0] idx_nxt;
  logic [IDX_W-1:0] idx_out_r;

  always_comb begin
    if (quo7_r != '0 && quo7_r < threshold_r) begin
      idx_nxt = IDX_W'(quo7_r * gain_r);
    end else begin
      idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d2_s1_r   <= d2_nxt;
      hit_s1_r  <= hit_nxt;
      sq2_r     <= sq2_nxt;
      for (int i = 0; i < NUM_BALLS; i++) begin
        lo2_r[i] <= d2_s1_r[i][5:0];
      end
      hit_s2_r  <= hit_s1_r;
      term_s3_r <= term_nxt;
      hit_s3_r  <= hit_s2_r;
      dvs4_r    <= dvs_nxt;
      dv4_r     <= dv4_nxt;
      num4_r    <= numerator_r[11:0];
      hit_s4_r  <= hit_s3_r;
      dvs5_r    <= dvs4_r;
      dv5_r     <= dv5_nxt;
      num5_r    <= num4_r[7:0];
      hit_s5_r  <= hit_s4_r;
      dvs6_r    <= dvs5_r;
      dv6_r     <= dv6_nxt;
      num6_r    <= num5_r[3:0];
      hit_s6_r  <= hit_s5_r;
      quo7_r    <= dv7_nxt.quo;
      hit_s7_r  <= hit_s6_r;
      idx_out_r <= idx_nxt;
      hit_out_r <= hit_s7_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_palette_index = idx_out_r;
  assign out_on_ball       = hit_out_r;

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && adv |=> out_valid_r)
    else $error("word in last stage not moved to output");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v7_r && !adv |=> v7_r)
    else $error("word in last stage lost during stall");

  a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> (sq2_r[0].rem <= {2'b00, sq2_r[0].root, 1'b0}) &&
             (sq2_r[1].rem <= {2'b00, sq2_r[1].root, 1'b0}) &&
             (sq2_r[2].rem <= {2'b00, sq2_r[2].root, 1'b0}))
    else $error("square root remainder out of range");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    v5_r |-> (dv5_r.rem < dvs5_r) && (dvs5_r != '0))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire
